@@ hdl/sts_pkg.sv @@
// ---------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the slot table scheduler: slot cell
// contents, cell control group and admit status codes.
// ---------------------------------------------------------------------------
package sts_pkg;

    localparam int SLOT_W    = 6;
    localparam int MAX_SLOTS = 64;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef struct packed {
        logic      busy;
        slot_idx_t owner;
    } slot_t;

    typedef struct packed {
        logic      shift;
        logic      claim;
        slot_idx_t owner;
    } cell_ctl_t;

endpackage

@@ hdl/slot_table_realtime_scheduler.sv @@
// ---------------------------------------------------------------------------
// slot_table_realtime_scheduler
// Cyclic slot table with admit and tick handling on a rotating cell ring.
// ---------------------------------------------------------------------------
// The slot table lives in a ring of SLOTS cells that rests with cell i
// holding slot i. An admit first checks range and conflicts in S_CHECK
// against the resting ring; a rejected admit then finishes, an accepted one
// rotates the ring once round and stamps the new owner into each requested
// slot as it wraps from head to tail. A tick rotates the ring once round
// and picks up the owner of the current second as it passes the head. An
// item holds the block until its result is loaded into the output
// register. One result beat is given per item; the next item is taken
// while that beat still waits at the output register.
// ---------------------------------------------------------------------------
module slot_table_realtime_scheduler #(
    parameter int SLOTS = 60
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [5:0] start_slot,
    input  logic [5:0] duration,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] admit_status,
    output logic [5:0] new_program,
    output logic       stop_valid,
    output logic [5:0] stop_program,
    output logic       start_valid,
    output logic [5:0] start_program,
    output logic [5:0] tick_slot
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_LAP   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    localparam logic [sts_pkg::SLOT_W-1:0] LAST_SLOT = sts_pkg::SLOT_W'(SLOTS - 1);
    localparam logic [sts_pkg::SLOT_W:0]   SLOTS_EXT = (sts_pkg::SLOT_W + 1)'(SLOTS);

    state_t state_reg, state_next;

    logic                        type_reg;
    logic [sts_pkg::SLOT_W-1:0]  start_reg;
    logic [sts_pkg::SLOT_W-1:0]  dur_reg;
    logic [sts_pkg::SLOT_W-1:0]  lap_reg;
    logic [sts_pkg::MAX_SLOTS-1:0] mask_reg;
    logic [sts_pkg::MAX_SLOTS-1:0] mask_next;

    logic [sts_pkg::SLOT_W-1:0]  count_reg, count_next;
    logic                        run_valid_reg, run_valid_next;
    logic [sts_pkg::SLOT_W-1:0]  run_prog_reg, run_prog_next;
    logic [sts_pkg::SLOT_W-1:0]  sec_reg, sec_next;

    sts_pkg::status_t            res_status_reg, res_status_next;
    logic [sts_pkg::SLOT_W-1:0]  res_new_reg, res_new_next;
    logic                        res_stop_reg, res_stop_next;
    logic [sts_pkg::SLOT_W-1:0]  res_stop_prog_reg, res_stop_prog_next;
    logic                        res_start_reg, res_start_next;
    logic [sts_pkg::SLOT_W-1:0]  res_start_prog_reg, res_start_prog_next;
    logic [sts_pkg::SLOT_W-1:0]  res_tick_reg, res_tick_next;

    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_status_reg;
    logic [5:0]                  out_new_reg;
    logic                        out_stop_reg;
    logic [5:0]                  out_stop_prog_reg;
    logic                        out_start_reg;
    logic [5:0]                  out_start_prog_reg;
    logic [5:0]                  out_tick_reg;

    sts_pkg::slot_t              cell_q [SLOTS];
    logic [sts_pkg::MAX_SLOTS-1:0] busy_vec;
    logic [sts_pkg::MAX_SLOTS-1:0] req_mask;
    logic [sts_pkg::SLOT_W:0]    req_end;
    logic                        range_err;
    logic                        conflict;
    logic                        ring_shift;
    logic                        ring_claim;
    logic                        lap_end;
    logic                        out_free;
    logic                        in_fire;

    // ---------------------------------------------------------------------
    // Slot ring
    // ---------------------------------------------------------------------
    assign ring_shift = (state_reg == S_LAP);
    assign ring_claim = ring_shift && !type_reg && mask_reg[lap_reg];

    genvar gi;
    generate
        for (gi = 0; gi < sts_pkg::MAX_SLOTS; gi++)
        begin : g_busy
            if (gi < SLOTS)
            begin : g_used
                assign busy_vec[gi] = cell_q[gi].busy;
            end
            else
            begin : g_unused
                assign busy_vec[gi] = 1'b0;
            end
        end

        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            sts_pkg::cell_ctl_t ctl;
            sts_pkg::slot_t     din;

            if (gi == SLOTS - 1)
            begin : g_tail
                // wrap the head back in at the tail, stamping claimed slots
                assign din       = cell_q[0];
                assign ctl.claim = ring_claim;
            end
            else
            begin : g_body
                assign din       = cell_q[gi + 1];
                assign ctl.claim = 1'b0;
            end
            assign ctl.shift = ring_shift;
            assign ctl.owner = res_new_reg;

            sts_cell u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .ctl  (ctl),
                .din  (din),
                .dout (cell_q[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------------
    // Admit check against the resting ring
    // ---------------------------------------------------------------------
    always_comb
    begin
        req_end   = {1'b0, start_reg} + {1'b0, dur_reg};
        range_err = (req_end > SLOTS_EXT);
        req_mask  = ((sts_pkg::MAX_SLOTS'(1) << dur_reg) - sts_pkg::MAX_SLOTS'(1))
                    << start_reg;
        conflict  = |(busy_vec & req_mask);
    end

    // ---------------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign lap_end  = (lap_reg == LAST_SLOT);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next          = state_reg;
        mask_next           = mask_reg;
        count_next          = count_reg;
        run_valid_next      = run_valid_reg;
        run_prog_next       = run_prog_reg;
        sec_next            = sec_reg;
        res_status_next     = res_status_reg;
        res_new_next        = res_new_reg;
        res_stop_next       = res_stop_reg;
        res_stop_prog_next  = res_stop_prog_reg;
        res_start_next      = res_start_reg;
        res_start_prog_next = res_start_prog_reg;
        res_tick_next       = res_tick_reg;
        out_valid_next      = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_new_next        = '0;
                    res_stop_next       = 1'b0;
                    res_stop_prog_next  = '0;
                    res_start_next      = 1'b0;
                    res_start_prog_next = '0;
                    mask_next           = '0;
                    if (req_type)
                    begin
                        res_status_next = sts_pkg::ST_NONE;
                        res_tick_next   = sec_reg;
                        state_next      = S_LAP;
                    end
                    else
                    begin
                        res_status_next = sts_pkg::ST_OK;
                        res_tick_next   = '0;
                        state_next      = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (range_err)
                begin
                    res_status_next = sts_pkg::ST_RANGE;
                    state_next      = S_DONE;
                end
                else if (conflict)
                begin
                    res_status_next = sts_pkg::ST_CONFLICT;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_status_next = sts_pkg::ST_OK;
                    res_new_next    = count_reg;
                    count_next      = count_reg + 1'b1;
                    mask_next       = req_mask;
                    state_next      = S_LAP;
                end
            end
            S_LAP:
            begin
                // the head holds slot lap_reg this cycle
                if (type_reg && (lap_reg == sec_reg))
                begin
                    if (cell_q[0].busy)
                    begin
                        if (!run_valid_reg || (run_prog_reg != cell_q[0].owner))
                        begin
                            res_stop_next      = run_valid_reg;
                            res_stop_prog_next = run_valid_reg ? run_prog_reg : '0;
                            run_valid_next     = 1'b1;
                            run_prog_next      = cell_q[0].owner;
                        end
                        res_start_next      = 1'b1;
                        res_start_prog_next = cell_q[0].owner;
                    end
                    else if (run_valid_reg)
                    begin
                        res_stop_next      = 1'b1;
                        res_stop_prog_next = run_prog_reg;
                        run_valid_next     = 1'b0;
                    end
                end
                if (lap_end)
                begin
                    if (type_reg)
                    begin
                        sec_next = (sec_reg == LAST_SLOT) ? '0 : sec_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lap_reg       <= '0;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_prog_reg  <= '0;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lap_reg       <= (state_reg == S_LAP && !lap_end) ? lap_reg + 1'b1 : '0;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_prog_reg  <= run_prog_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            type_reg  <= req_type;
            start_reg <= start_slot;
            dur_reg   <= duration;
        end
        mask_reg           <= mask_next;
        res_status_reg     <= res_status_next;
        res_new_reg        <= res_new_next;
        res_stop_reg       <= res_stop_next;
        res_stop_prog_reg  <= res_stop_prog_next;
        res_start_reg      <= res_start_next;
        res_start_prog_reg <= res_start_prog_next;
        res_tick_reg       <= res_tick_next;
        // load the output beat once the previous one has gone
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg     <= res_status_reg;
            out_new_reg        <= res_new_reg;
            out_stop_reg       <= res_stop_reg;
            out_stop_prog_reg  <= res_stop_prog_reg;
            out_start_reg      <= res_start_reg;
            out_start_prog_reg <= res_start_prog_reg;
            out_tick_reg       <= res_tick_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign admit_status  = out_status_reg;
    assign new_program   = out_new_reg;
    assign stop_valid    = out_stop_reg;
    assign stop_program  = out_stop_prog_reg;
    assign start_valid   = out_start_reg;
    assign start_program = out_start_prog_reg;
    assign tick_slot     = out_tick_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg <= LAST_SLOT)
        else $error("current second out of range");

    a_lap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAP) |-> (lap_reg <= LAST_SLOT))
        else $error("lap counter out of range");

    a_claim_admit: assert property (@(posedge clk) disable iff (!rst_n)
        ring_claim |-> (!type_reg && res_status_reg == sts_pkg::ST_OK))
        else $error("slot claimed outside an accepted admit");

    a_lap_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAP && lap_end) |=> (state_reg == S_DONE && lap_reg == '0))
        else $error("lap did not end cleanly");

    a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result beat not issued");

endmodule

@@ hdl/sts_cell.sv @@
// ---------------------------------------------------------------------------
// sts_cell
// One slot of the rotating slot ring: holds busy flag and owner, takes the
// neighbour's contents on a shift and marks itself owned on a claim.
// ---------------------------------------------------------------------------
module sts_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  sts_pkg::cell_ctl_t ctl,
    input  sts_pkg::slot_t    din,
    output sts_pkg::slot_t    dout
);

    logic              busy_reg;
    logic              busy_next;
    sts_pkg::slot_idx_t owner_reg;
    sts_pkg::slot_idx_t owner_next;

    always_comb
    begin
        busy_next  = busy_reg;
        owner_next = owner_reg;
        if (ctl.shift)
        begin
            // claim overrides the incoming slot as it wraps round
            if (ctl.claim)
            begin
                busy_next  = 1'b1;
                owner_next = ctl.owner;
            end
            else
            begin
                busy_next  = din.busy;
                owner_next = din.owner;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg <= owner_next;
    end

    assign dout.busy  = busy_reg;
    assign dout.owner = owner_reg;

endmodule

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the slot table scheduler. Admit and tick beats are
// driven on the input channel and predicted against a local copy of the slot
// table and run state. Every result beat is then compared field by field.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS           = 60;
    localparam int DRAIN_CYCLES    = SLOTS + 40;
    localparam int ITEMS_PER_PHASE = 610;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AT_BEAT    = 60;

    typedef enum logic {
        REQ_ADMIT = 1'b0,
        REQ_TICK  = 1'b1
    } req_kind_t;

    typedef struct packed {
        sts_pkg::status_t   status;
        sts_pkg::slot_idx_t new_prog;
        logic               stop_v;
        sts_pkg::slot_idx_t stop_prog;
        logic               start_v;
        sts_pkg::slot_idx_t start_prog;
        sts_pkg::slot_idx_t slot;
    } sched_beat_t;

    class sched_scoreboard;
        logic [sts_pkg::MAX_SLOTS-1:0] busy;
        sts_pkg::slot_idx_t            owner [sts_pkg::MAX_SLOTS];
        sts_pkg::slot_idx_t            next_prog;
        logic                          running;
        sts_pkg::slot_idx_t            run_prog;
        sts_pkg::slot_idx_t            second;
        sched_beat_t                   awaited [$];
        int                            errors;
        int                            beats_seen;

        function new();
            busy       = '0;
            next_prog  = '0;
            running    = 1'b0;
            run_prog   = '0;
            second     = '0;
            errors     = 0;
            beats_seen = 0;
        endfunction

        // Work out the beat an accepted request produces and advance the table.
        function void note_input(logic kind, sts_pkg::slot_idx_t first,
                                 sts_pkg::slot_idx_t len);
            sched_beat_t r;
            int          last;
            int          s;
            logic        clash;
            r = '0;
            if (kind == REQ_ADMIT)
            begin
                last  = int'(first) + int'(len);
                clash = 1'b0;
                if (last > SLOTS)
                begin
                    r.status = sts_pkg::ST_RANGE;
                end
                else
                begin
                    for (s = int'(first); s < last; s++)
                        if (busy[s])
                            clash = 1'b1;
                    if (clash)
                    begin
                        r.status = sts_pkg::ST_CONFLICT;
                    end
                    else
                    begin
                        // An empty run still uses up a program number
                        for (s = int'(first); s < last; s++)
                        begin
                            busy[s]  = 1'b1;
                            owner[s] = next_prog;
                        end
                        r.status   = sts_pkg::ST_OK;
                        r.new_prog = next_prog;
                        next_prog  = next_prog + 1'b1;
                    end
                end
            end
            else
            begin
                r.status = sts_pkg::ST_NONE;
                r.slot   = second;
                if (busy[second])
                begin
                    if (!running || run_prog != owner[second])
                    begin
                        if (running)
                        begin
                            r.stop_v    = 1'b1;
                            r.stop_prog = run_prog;
                        end
                        running  = 1'b1;
                        run_prog = owner[second];
                    end
                    r.start_v    = 1'b1;
                    r.start_prog = owner[second];
                end
                else if (running)
                begin
                    r.stop_v    = 1'b1;
                    r.stop_prog = run_prog;
                    running     = 1'b0;
                end
                second = (int'(second) == SLOTS - 1) ? '0 : second + 1'b1;
            end
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [5:0] want, logic [5:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(sched_beat_t got);
            sched_beat_t want;
            beats_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_field("admit_status",  6'(want.status),  6'(got.status));
            compare_field("new_program",   want.new_prog,    got.new_prog);
            compare_field("stop_valid",    6'(want.stop_v),  6'(got.stop_v));
            compare_field("stop_program",  want.stop_prog,   got.stop_prog);
            compare_field("start_valid",   6'(want.start_v), 6'(got.start_v));
            compare_field("start_program", want.start_prog,  got.start_prog);
            compare_field("tick_slot",     want.slot,        got.slot);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       req_type;
    logic [5:0] start_slot;
    logic [5:0] duration;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] admit_status;
    logic [5:0] new_program;
    logic       stop_valid;
    logic [5:0] stop_program;
    logic       start_valid;
    logic [5:0] start_program;
    logic [5:0] tick_slot;

    int tx_idle;
    int rx_idle;

    sched_scoreboard sb = new();

    slot_table_realtime_scheduler #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .start_slot   (start_slot),
        .duration     (duration),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .admit_status (admit_status),
        .new_program  (new_program),
        .stop_valid   (stop_valid),
        .stop_program (stop_program),
        .start_valid  (start_valid),
        .start_program(start_program),
        .tick_slot    (tick_slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Offer one request beat and hold it until the block takes it.
    task automatic send_item(logic kind, sts_pkg::slot_idx_t first,
                             sts_pkg::slot_idx_t len);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        req_type   = kind;
        start_slot = first;
        duration   = len;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_input(kind, first, len);
    endtask

    // Drop valid and hold off until every expected beat has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_item(REQ_TICK, sts_pkg::slot_idx_t'($urandom_range(0, 63)),
                      sts_pkg::slot_idx_t'($urandom_range(0, 63)));
        else if (pick < 65)
            send_item(REQ_ADMIT, sts_pkg::slot_idx_t'($urandom_range(0, SLOTS - 1)), '0);
        else if (pick < 90)
            send_item(REQ_ADMIT, sts_pkg::slot_idx_t'($urandom_range(0, SLOTS - 1)),
                      sts_pkg::slot_idx_t'($urandom_range(1, 4)));
        else
            send_item(REQ_ADMIT, sts_pkg::slot_idx_t'($urandom_range(0, SLOTS - 1)),
                      sts_pkg::slot_idx_t'($urandom_range(1, SLOTS)));
    endtask

    task automatic run_phase(int s_idle, int r_idle);
        int k;
        tx_idle = s_idle;
        rx_idle = r_idle;
        for (k = 0; k < ITEMS_PER_PHASE; k++)
            send_random();
    endtask

    // Receiver ready: random idling, plus one long hold to back the block up.
    initial
    begin
        bit held_once;
        held_once = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_once && sb.beats_seen == HOLD_AT_BEAT)
            begin
                held_once = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(0, 99) >= rx_idle);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
                sb.check_result({admit_status, new_program, stop_valid, stop_program,
                                 start_valid, start_program, tick_slot});
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_ADMIT;
        start_slot = '0;
        duration   = '0;
        out_ready  = 1'b0;
        tx_idle    = 25;
        rx_idle    = 49;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: free second with nothing running, empty run, edges of the cycle
        send_item(REQ_TICK,  6'd0,  6'd0);
        send_item(REQ_ADMIT, 6'd0,  6'd0);
        send_item(REQ_ADMIT, 6'd59, 6'd1);
        send_item(REQ_ADMIT, 6'd59, 6'd2);
        send_item(REQ_ADMIT, 6'd0,  6'd60);
        send_item(REQ_ADMIT, 6'd1,  6'd3);
        send_item(REQ_ADMIT, 6'd3,  6'd1);
        send_item(REQ_ADMIT, 6'd4,  6'd2);
        // Seconds 1..7: start, keep running, hand over, stop, stay idle
        send_item(REQ_TICK,  6'd63, 6'd63);
        send_item(REQ_TICK,  6'd0,  6'd0);
        send_item(REQ_TICK,  6'd0,  6'd0);
        send_item(REQ_TICK,  6'd0,  6'd0);
        send_item(REQ_TICK,  6'd0,  6'd0);
        send_item(REQ_TICK,  6'd0,  6'd0);
        send_item(REQ_TICK,  6'd0,  6'd0);
        send_item(REQ_ADMIT, 6'd40, 6'd19);
        send_item(REQ_ADMIT, 6'd1,  6'd59);
        send_item(REQ_ADMIT, 6'd2,  6'd59);
        send_item(REQ_ADMIT, 6'd58, 6'd0);
        wait_drained();

        run_phase(25, 49);
        wait_drained();
        run_phase(49, 25);
        wait_drained();
        run_phase(0, 0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sts_pkg.sv
hdl/sts_cell.sv
hdl/slot_table_realtime_scheduler.sv
verif/testbench.sv
